// ----- sv/dtas_pkg.sv -----
package dtas_pkg;

	// field widths
	localparam int DATE_W = 27;
	localparam int TIME_W = 18;
	localparam int YEAR_W = 14;
	localparam int HOUR_W = 5;
	localparam int PAIR_W = 7;
	localparam int REM_W  = 14;
	localparam int DAY_W  = 5;

	// number of register stages from request to result
	localparam int NUM_STAGES = 7;

	// action codes
	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_SUB = 1'b1;

	// decimal scale factors
	localparam logic [13:0] SCALE_10K = 14'd10000;
	localparam logic [6:0]  SCALE_100 = 7'd100;

	// reciprocals: x/10000 = ((x>>4)*M)>>33 for 23 bits, >>24 with M' for 14 bits,
	// x/100 = ((x>>2)*5243)>>17 for x below 10000
	localparam logic [23:0] YEAR_MUL = 24'd13743896;
	localparam logic [14:0] HOUR_MUL = 15'd26844;
	localparam logic [12:0] CENT_MUL = 13'd5243;

	// calendar and clock limits
	localparam logic [13:0] YEAR_MAX      = 14'd9999;
	localparam logic [6:0]  MONTH_MAX     = 7'd12;
	localparam logic [4:0]  DEC_LEN       = 5'd31;
	localparam logic [4:0]  FEB_LEAP_LEN  = 5'd29;
	localparam logic [6:0]  SEC_MAX       = 7'd59;
	localparam logic [7:0]  SEC_PER_MIN   = 8'd60;
	localparam logic [4:0]  HOUR_MAX      = 5'd23;
	localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
	localparam logic [17:0] INTERVAL_MAX  = 18'd240000;
	localparam logic [17:0] TIME_MAX      = 18'd235959;
	localparam logic [26:0] DATE_MAX      = 27'd99991231;

	localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} dtas_en_t;

	// request split into decimal fields
	typedef struct packed {
		logic              action;
		logic              iv_big;
		logic [DATE_W-1:0] dv;
		logic [TIME_W-1:0] tv;
		logic [YEAR_W-1:0] year;
		logic [PAIR_W-1:0] month;
		logic [PAIR_W-1:0] day;
		logic [HOUR_W-1:0] hour;
		logic [PAIR_W-1:0] minute;
		logic [PAIR_W-1:0] second;
		logic [HOUR_W-1:0] int_h;
		logic [PAIR_W-1:0] int_m;
		logic [PAIR_W-1:0] int_s;
	} dtas_fields_t;

	// adjusted date and time
	typedef struct packed {
		logic              bad;
		logic [DATE_W-1:0] dv;
		logic [TIME_W-1:0] tv;
		logic [YEAR_W-1:0] year;
		logic [PAIR_W-1:0] month;
		logic [PAIR_W-1:0] day;
		logic [HOUR_W-1:0] hour;
		logic [PAIR_W-1:0] minute;
		logic [PAIR_W-1:0] second;
	} dtas_adj_t;

	// quotient by 100 of a value below 10000
	function automatic logic [PAIR_W-1:0] div100(input logic [REM_W-1:0] r);
		logic [24:0] prod;
		prod = 25'(r[REM_W-1:2]) * 25'(CENT_MUL);
		return prod[23:17];
	endfunction

	// remainder by 100 given the quotient
	function automatic logic [PAIR_W-1:0] mod100(input logic [REM_W-1:0] r,
			input logic [PAIR_W-1:0] q);
		logic [REM_W-1:0] diff;
		diff = r - REM_W'(q) * REM_W'(SCALE_100);
		return diff[PAIR_W-1:0];
	endfunction

	// month length, zero for a month outside 1..12; leap year when divisible by 4
	function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] year,
			input logic [PAIR_W-1:0] month);
		logic [DAY_W-1:0] n;
		if (month == 7'd0 || month > MONTH_MAX) begin
			n = '0;
		end else if (month == 7'd2 && year[1:0] == 2'b00) begin
			n = FEB_LEAP_LEN;
		end else begin
			n = MONTH_LEN[month[3:0]];
		end
		return n;
	endfunction

endpackage

// ----- sv/dtas_if.sv -----
// request channel
interface dtas_req_if;
	import dtas_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [DATE_W-1:0] date_value;
	logic [TIME_W-1:0] time_value;
	logic [TIME_W-1:0] interval;

	modport source (output valid, action, date_value, time_value, interval, input ready);
	modport sink (input valid, action, date_value, time_value, interval, output ready);
endinterface

// result channel
interface dtas_res_if;
	import dtas_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATE_W-1:0] new_date;
	logic [TIME_W-1:0] new_time;
	logic              bad_input;

	modport source (output valid, new_date, new_time, bad_input, input ready);
	modport sink (input valid, new_date, new_time, bad_input, output ready);
endinterface

// ----- sv/dtas_split.sv -----
module dtas_split (
	input  logic                          clk,
	input  dtas_pkg::dtas_en_t            en,
	input  logic                          action,
	input  logic [dtas_pkg::DATE_W-1:0]   date_value,
	input  logic [dtas_pkg::TIME_W-1:0]   time_value,
	input  logic [dtas_pkg::TIME_W-1:0]   interval,
	output dtas_pkg::dtas_fields_t        fields
);
	import dtas_pkg::*;

	// stage 1: request register
	logic              act_s1;
	logic [DATE_W-1:0] dv_s1;
	logic [TIME_W-1:0] tv_s1;
	logic [TIME_W-1:0] iv_s1;

	// stage 2: high parts
	logic              act_s2, ivbig_s2;
	logic [DATE_W-1:0] dv_s2;
	logic [TIME_W-1:0] tv_s2, iv_s2;
	logic [YEAR_W-1:0] year_s2;
	logic [HOUR_W-1:0] hour_s2, ih_s2;

	// stage 3: low four digits
	logic              act_s3, ivbig_s3;
	logic [DATE_W-1:0] dv_s3;
	logic [TIME_W-1:0] tv_s3;
	logic [YEAR_W-1:0] year_s3;
	logic [HOUR_W-1:0] hour_s3, ih_s3;
	logic [REM_W-1:0]  remd_s3, remt_s3, remi_s3;

	// stage 4: middle digit pairs
	logic              act_s4, ivbig_s4;
	logic [DATE_W-1:0] dv_s4;
	logic [TIME_W-1:0] tv_s4;
	logic [YEAR_W-1:0] year_s4;
	logic [HOUR_W-1:0] hour_s4, ih_s4;
	logic [REM_W-1:0]  remd_s4, remt_s4, remi_s4;
	logic [PAIR_W-1:0] month_s4, minute_s4, im_s4;

	// stage 5: all fields
	dtas_fields_t fields_s5;

	logic [46:0]       yprod;
	logic [28:0]       hprod, iprod;
	logic [DATE_W-1:0] dprod, ddiff;
	logic [TIME_W-1:0] tprod, tdiff, ipr2, idiff;

	// divide by 10000 with reciprocal multiplies
	assign yprod = 47'(dv_s1[DATE_W-1:4]) * 47'(YEAR_MUL);
	assign hprod = 29'(tv_s1[TIME_W-1:4]) * 29'(HOUR_MUL);
	assign iprod = 29'(iv_s1[TIME_W-1:4]) * 29'(HOUR_MUL);

	// remainders below 10000
	assign dprod = DATE_W'(year_s2) * DATE_W'(SCALE_10K);
	assign ddiff = dv_s2 - dprod;
	assign tprod = TIME_W'(hour_s2) * TIME_W'(SCALE_10K);
	assign tdiff = tv_s2 - tprod;
	assign ipr2  = TIME_W'(ih_s2) * TIME_W'(SCALE_10K);
	assign idiff = iv_s2 - ipr2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			act_s1 <= action;
			dv_s1  <= date_value;
			tv_s1  <= time_value;
			iv_s1  <= interval;
		end
		if (en.s2) begin
			act_s2   <= act_s1;
			ivbig_s2 <= iv_s1 > INTERVAL_MAX;
			dv_s2    <= dv_s1;
			tv_s2    <= tv_s1;
			iv_s2    <= iv_s1;
			year_s2  <= yprod[46:33];
			hour_s2  <= hprod[28:24];
			ih_s2    <= iprod[28:24];
		end
		if (en.s3) begin
			act_s3   <= act_s2;
			ivbig_s3 <= ivbig_s2;
			dv_s3    <= dv_s2;
			tv_s3    <= tv_s2;
			year_s3  <= year_s2;
			hour_s3  <= hour_s2;
			ih_s3    <= ih_s2;
			remd_s3  <= ddiff[REM_W-1:0];
			remt_s3  <= tdiff[REM_W-1:0];
			remi_s3  <= idiff[REM_W-1:0];
		end
		if (en.s4) begin
			act_s4    <= act_s3;
			ivbig_s4  <= ivbig_s3;
			dv_s4     <= dv_s3;
			tv_s4     <= tv_s3;
			year_s4   <= year_s3;
			hour_s4   <= hour_s3;
			ih_s4     <= ih_s3;
			remd_s4   <= remd_s3;
			remt_s4   <= remt_s3;
			remi_s4   <= remi_s3;
			month_s4  <= div100(remd_s3);
			minute_s4 <= div100(remt_s3);
			im_s4     <= div100(remi_s3);
		end
		if (en.s5) begin
			fields_s5.action <= act_s4;
			fields_s5.iv_big <= ivbig_s4;
			fields_s5.dv     <= dv_s4;
			fields_s5.tv     <= tv_s4;
			fields_s5.year   <= year_s4;
			fields_s5.month  <= month_s4;
			fields_s5.day    <= mod100(remd_s4, month_s4);
			fields_s5.hour   <= hour_s4;
			fields_s5.minute <= minute_s4;
			fields_s5.second <= mod100(remt_s4, minute_s4);
			fields_s5.int_h  <= ih_s4;
			fields_s5.int_m  <= im_s4;
			fields_s5.int_s  <= mod100(remi_s4, im_s4);
		end
	end

	assign fields = fields_s5;

endmodule

// ----- sv/dtas_adjust.sv -----
module dtas_adjust (
	input  logic                   clk,
	input  dtas_pkg::dtas_en_t     en,
	input  dtas_pkg::dtas_fields_t fields,
	output dtas_pkg::dtas_adj_t    adj
);
	import dtas_pkg::*;

	dtas_adj_t adj_s6;

	logic [DAY_W-1:0]  dim, dim_prev;
	logic              bad_in, spill, ovf, is_sub;
	logic [7:0]        s_sum, m_sum, s_add, m_add;
	logic [7:0]        s_sub, m_sub, m_take;
	logic [5:0]        h_sum, h_add, h_take, h_sub;
	logic              c_s, c_m, spill_add, b_s, b_m, spill_sub;
	logic [YEAR_W-1:0] year_n;
	logic [PAIR_W-1:0] month_n, day_n;

	assign is_sub = fields.action == ACT_SUB;

	// range checks on date, time and interval
	assign dim      = days_in(fields.year, fields.month);
	assign dim_prev = days_in(fields.year, fields.month - 7'd1);
	assign bad_in = (fields.year > YEAR_MAX) || (fields.day == 7'd0) ||
		(fields.day > PAIR_W'(dim)) || (fields.hour > HOUR_MAX) ||
		(fields.minute > SEC_MAX) || (fields.second > SEC_MAX) ||
		fields.iv_big || (fields.int_m > SEC_MAX) || (fields.int_s > SEC_MAX);

	// add with carry per unit
	assign s_sum     = 8'(fields.second) + 8'(fields.int_s);
	assign c_s       = s_sum > 8'(SEC_MAX);
	assign s_add     = c_s ? s_sum - SEC_PER_MIN : s_sum;
	assign m_sum     = 8'(fields.minute) + 8'(fields.int_m) + 8'(c_s);
	assign c_m       = m_sum > 8'(SEC_MAX);
	assign m_add     = c_m ? m_sum - SEC_PER_MIN : m_sum;
	assign h_sum     = 6'(fields.hour) + 6'(fields.int_h) + 6'(c_m);
	assign spill_add = h_sum > 6'(HOUR_MAX);
	assign h_add     = spill_add ? h_sum - HOURS_PER_DAY : h_sum;

	// subtract with borrow per unit
	assign b_s       = fields.second < fields.int_s;
	assign s_sub     = b_s ? 8'(fields.second) + SEC_PER_MIN - 8'(fields.int_s)
		: 8'(fields.second) - 8'(fields.int_s);
	assign m_take    = 8'(fields.int_m) + 8'(b_s);
	assign b_m       = 8'(fields.minute) < m_take;
	assign m_sub     = b_m ? 8'(fields.minute) + SEC_PER_MIN - m_take
		: 8'(fields.minute) - m_take;
	assign h_take    = 6'(fields.int_h) + 6'(b_m);
	assign spill_sub = 6'(fields.hour) < h_take;
	assign h_sub     = spill_sub ? 6'(fields.hour) + HOURS_PER_DAY - h_take
		: 6'(fields.hour) - h_take;

	assign spill = is_sub ? spill_sub : spill_add;

	// one day forward or back
	always_comb begin
		year_n  = fields.year;
		month_n = fields.month;
		day_n   = fields.day;
		ovf     = 1'b0;
		if (spill && !is_sub) begin
			if (fields.day == PAIR_W'(dim)) begin
				day_n = 7'd1;
				if (fields.month == MONTH_MAX) begin
					month_n = 7'd1;
					if (fields.year == YEAR_MAX) begin
						ovf = 1'b1;
					end else begin
						year_n = fields.year + 14'd1;
					end
				end else begin
					month_n = fields.month + 7'd1;
				end
			end else begin
				day_n = fields.day + 7'd1;
			end
		end else if (spill && is_sub) begin
			priority if (fields.day > 7'd1) begin
				day_n = fields.day - 7'd1;
			end else if (fields.month > 7'd1) begin
				month_n = fields.month - 7'd1;
				day_n   = PAIR_W'(dim_prev);
			end else if (fields.year == '0) begin
				ovf = 1'b1;
			end else begin
				year_n  = fields.year - 14'd1;
				month_n = MONTH_MAX;
				day_n   = PAIR_W'(DEC_LEN);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			adj_s6.bad    <= bad_in || ovf;
			adj_s6.dv     <= fields.dv;
			adj_s6.tv     <= fields.tv;
			adj_s6.year   <= year_n;
			adj_s6.month  <= month_n;
			adj_s6.day    <= day_n;
			adj_s6.hour   <= is_sub ? h_sub[HOUR_W-1:0] : h_add[HOUR_W-1:0];
			adj_s6.minute <= is_sub ? m_sub[PAIR_W-1:0] : m_add[PAIR_W-1:0];
			adj_s6.second <= is_sub ? s_sub[PAIR_W-1:0] : s_add[PAIR_W-1:0];
		end
	end

	assign adj = adj_s6;

endmodule

// ----- sv/dtas_pack.sv -----
module dtas_pack (
	input  logic                        clk,
	input  dtas_pkg::dtas_en_t          en,
	input  dtas_pkg::dtas_adj_t         adj,
	output logic [dtas_pkg::DATE_W-1:0] new_date,
	output logic [dtas_pkg::TIME_W-1:0] new_time,
	output logic                        bad_input
);
	import dtas_pkg::*;

	logic [DATE_W-1:0] date_s7, date_n;
	logic [TIME_W-1:0] time_s7, time_n;
	logic              bad_s7;

	// pack back to decimal
	assign date_n = DATE_W'(adj.year) * DATE_W'(SCALE_10K) +
		DATE_W'(adj.month) * DATE_W'(SCALE_100) + DATE_W'(adj.day);
	assign time_n = TIME_W'(adj.hour) * TIME_W'(SCALE_10K) +
		TIME_W'(adj.minute) * TIME_W'(SCALE_100) + TIME_W'(adj.second);

	// result register, rejected requests pass through
	always_ff @(posedge clk) begin
		if (en.s7) begin
			date_s7 <= adj.bad ? adj.dv : date_n;
			time_s7 <= adj.bad ? adj.tv : time_n;
			bad_s7  <= adj.bad;
		end
	end

	assign new_date  = date_s7;
	assign new_time  = time_s7;
	assign bad_input = bad_s7;

endmodule

// ----- sv/date_time_add_subtract.sv -----
// seven register stages; a result is valid once its accepted request has passed them all
// one request per cycle but for result stalls; stages move independently, bubbles fill in
// the pipeline of 7 stage registers is the only limit on items in flight
// reset: arst_n clears all stage valid bits at once, payload registers are not reset
// ready to accept right after reset
module date_time_add_subtract (
	input logic        clk,
	input logic        arst_n,
	dtas_req_if.sink   req,
	dtas_res_if.source result
);
	import dtas_pkg::*;

	logic [NUM_STAGES-1:0] vld_q, vld_prev, rdy;
	dtas_en_t              en;
	dtas_fields_t          fields;
	dtas_adj_t             adj;

	// a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_prev = {vld_q[NUM_STAGES-2:0], req.valid};
	assign en       = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3],
		s5: rdy[4], s6: rdy[5], s7: rdy[6]};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy & vld_prev) | (~rdy & vld_q);
		end
	end

	assign req.ready    = rdy[0];
	assign result.valid = vld_q[NUM_STAGES-1];

	dtas_split u_split (
		.clk        (clk),
		.en         (en),
		.action     (req.action),
		.date_value (req.date_value),
		.time_value (req.time_value),
		.interval   (req.interval),
		.fields     (fields)
	);

	dtas_adjust u_adjust (
		.clk    (clk),
		.en     (en),
		.fields (fields),
		.adj    (adj)
	);

	dtas_pack u_pack (
		.clk       (clk),
		.en        (en),
		.adj       (adj),
		.new_date  (result.new_date),
		.new_time  (result.new_time),
		.bad_input (result.bad_input)
	);

	// back pressure only when every stage holds a request
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (&vld_q) && !result.ready)
		else $error("request refused with an empty stage");

	// accepted request lands in the first stage
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_q[0])
		else $error("accepted request lost");

	// good results are in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.bad_input |-> result.new_time <= TIME_MAX)
		else $error("time out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.bad_input |-> result.new_date <= DATE_MAX)
		else $error("date out of range");

endmodule

// ----- tb/date_time_add_subtract_tb.sv -----
`timescale 1ns / 100ps

module date_time_add_subtract_tb;
	import dtas_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [DATE_W-1:0] date_out;
		logic [TIME_W-1:0] tod_out;
		logic              bad;
	} stamp_t;

	typedef enum int {KIND_CLEAN, KIND_BROKEN, KIND_RAW} item_kind_t;
	typedef enum int {
		FLAW_MONTH, FLAW_DAY, FLAW_HOUR, FLAW_MINUTE, FLAW_SECOND,
		FLAW_SPAN, FLAW_SPAN_MIN, FLAW_SPAN_SEC
	} flaw_t;

	logic clk;
	logic arst_n;

	dtas_req_if req_ch ();
	dtas_res_if res_ch ();

	date_time_add_subtract u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.result (res_ch)
	);

	stamp_t awaited_stamps [$];
	stamp_t want_stamp;
	int     error_count = 0;
	int     quiet_cycles = 0;
	int     sink_hold = 0;
	int     sink_stall = 0;
	bit     source_steady = 1'b0;
	bit     sink_steady = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// days in a month, zero for a month outside 1..12
	function automatic int unsigned days_per_month(input int unsigned yr, input int unsigned mo);
		case (mo)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return (yr % 4 == 0) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// predicted date and time after moving by the interval
	function automatic stamp_t adjust_stamp(input logic act, input logic [DATE_W-1:0] dv,
			input logic [TIME_W-1:0] tv, input logic [TIME_W-1:0] iv);
		int unsigned d, t, span;
		int unsigned yr, mo, dy, hr, mi, se, sp_h, sp_m, sp_s;
		int          h, m, s, c;
		logic        bad;
		logic        spill;
		stamp_t      r;
		d = dv;
		t = tv;
		span = iv;
		yr = d / 10000;
		mo = (d / 100) % 100;
		dy = d % 100;
		hr = t / 10000;
		mi = (t / 100) % 100;
		se = t % 100;
		sp_h = span / 10000;
		sp_m = (span / 100) % 100;
		sp_s = span % 100;
		h = hr;
		m = mi;
		s = se;
		spill = 1'b0;
		bad = (yr > 9999) || (dy < 1) || (dy > days_per_month(yr, mo)) ||
			(hr > 23) || (mi > 59) || (se > 59) ||
			(span > 240000) || (sp_m > 59) || (sp_s > 59);

		if (!bad && act == ACT_ADD) begin
			s = s + sp_s;
			c = 0;
			if (s > 59) begin s = s - 60; c = 1; end
			m = m + sp_m + c;
			c = 0;
			if (m > 59) begin m = m - 60; c = 1; end
			h = h + sp_h + c;
			if (h > 23) begin h = h - 24; spill = 1'b1; end
			// one day forward across month and year ends
			if (spill) begin
				dy++;
				if (dy > days_per_month(yr, mo)) begin
					dy = 1;
					mo++;
					if (mo > 12) begin
						mo = 1;
						if (yr == 9999) bad = 1'b1;
						else yr++;
					end
				end
			end
		end else if (!bad) begin
			s = s - sp_s;
			c = 0;
			if (s < 0) begin s = s + 60; c = 1; end
			m = m - sp_m - c;
			c = 0;
			if (m < 0) begin m = m + 60; c = 1; end
			h = h - sp_h - c;
			if (h < 0) begin h = h + 24; spill = 1'b1; end
			// one day back across month and year starts
			if (spill) begin
				if (dy > 1) begin
					dy--;
				end else if (mo > 1) begin
					mo--;
					dy = days_per_month(yr, mo);
				end else if (yr == 0) begin
					bad = 1'b1;
				end else begin
					yr--;
					mo = 12;
					dy = 31;
				end
			end
		end

		r.bad = bad;
		if (bad) begin
			r.date_out = dv;
			r.tod_out = tv;
		end else begin
			r.date_out = DATE_W'(yr * 10000 + mo * 100 + dy);
			r.tod_out = TIME_W'(h * 10000 + m * 100 + s);
		end
		return r;
	endfunction

	// idle length: mostly short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 12) return $urandom_range(1, 3);
		if (r < 15) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// offer one request and record its predicted result on acceptance
	task automatic send_shift(input logic act, input logic [DATE_W-1:0] dv,
			input logic [TIME_W-1:0] tv, input logic [TIME_W-1:0] iv);
		int unsigned gap;
		gap = (!source_steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.date_value = dv;
		req_ch.time_value = tv;
		req_ch.interval = iv;
		do @(posedge clk); while (!req_ch.ready);
		awaited_stamps.push_back(adjust_stamp(act, dv, tv, iv));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_results_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (awaited_stamps.size() != 0) @(posedge clk);
	endtask

	// random request: well-formed, one field broken, or raw bits
	task automatic send_random_shift(input item_kind_t kind);
		int unsigned yr, mo, dy, len, hr, mi, se, sp_h, sp_m, sp_s;
		logic [TIME_W-1:0] iv;
		logic              act;
		flaw_t             flaw;
		bit                span_over;
		act = $urandom_range(0, 1) ? ACT_SUB : ACT_ADD;
		if (kind == KIND_RAW) begin
			send_shift(act, DATE_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()));
		end else begin
			case ($urandom_range(0, 9))
				0:       yr = 0;
				1:       yr = 9999;
				default: yr = $urandom_range(0, 9999);
			endcase
			mo = $urandom_range(1, 12);
			len = days_per_month(yr, mo);
			case ($urandom_range(0, 5))
				0, 1:    dy = len;
				2:       dy = 1;
				default: dy = $urandom_range(1, len);
			endcase
			case ($urandom_range(0, 3))
				0:       hr = 0;
				1:       hr = 23;
				default: hr = $urandom_range(0, 23);
			endcase
			mi = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 59 : 0) : $urandom_range(0, 59);
			se = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 59 : 0) : $urandom_range(0, 59);
			if ($urandom_range(0, 9) == 0) begin
				sp_h = 24;
				sp_m = 0;
				sp_s = 0;
			end else begin
				sp_h = $urandom_range(0, 23);
				sp_m = $urandom_range(0, 3) == 0 ? 59 : $urandom_range(0, 59);
				sp_s = $urandom_range(0, 3) == 0 ? 59 : $urandom_range(0, 59);
			end
			span_over = 1'b0;
			if (kind == KIND_BROKEN) begin
				flaw = flaw_t'($urandom_range(0, 7));
				case (flaw)
					FLAW_MONTH:    mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
					FLAW_DAY:      dy = $urandom_range(0, 1) ? 0 : $urandom_range(len + 1, 99);
					FLAW_HOUR:     hr = $urandom_range(24, 25);
					FLAW_MINUTE:   mi = $urandom_range(60, 99);
					FLAW_SECOND:   se = $urandom_range(60, 99);
					FLAW_SPAN:     span_over = 1'b1;
					FLAW_SPAN_MIN: sp_m = $urandom_range(60, 99);
					FLAW_SPAN_SEC: sp_s = $urandom_range(60, 99);
					default:       span_over = 1'b1;
				endcase
			end
			iv = span_over ? TIME_W'($urandom_range(240001, 262143))
				: TIME_W'(sp_h * 10000 + sp_m * 100 + sp_s);
			send_shift(act, DATE_W'(yr * 10000 + mo * 100 + dy),
				TIME_W'(hr * 10000 + mi * 100 + se), iv);
		end
	endtask

	// month and year ends, leap days, overflow and malformed fields
	task automatic test_directed_cases();
		send_shift(ACT_ADD, 20240229, 233000, 3000);
		send_shift(ACT_ADD, 20230228, 235959, 1);
		send_shift(ACT_SUB, 20240301, 0, 1);
		send_shift(ACT_SUB, 20230301, 1000, 240000);
		send_shift(ACT_ADD, 99991231, 235959, 1);
		send_shift(ACT_SUB, 101, 0, 1);
		send_shift(ACT_ADD, 1231, 120000, 240000);
		send_shift(ACT_SUB, 99990101, 0, 240000);
		send_shift(ACT_ADD, 20230229, 100000, 100);
		send_shift(ACT_ADD, 19000229, 235959, 1);
		send_shift(ACT_ADD, 20241301, 100000, 100);
		send_shift(ACT_ADD, 20240001, 100000, 100);
		send_shift(ACT_SUB, 20240100, 100000, 100);
		send_shift(ACT_ADD, 20240431, 100000, 100);
		send_shift(ACT_ADD, 20240430, 230000, 10000);
		send_shift(ACT_SUB, 20240501, 5959, 10000);
		send_shift(ACT_ADD, 20240101, 240000, 0);
		send_shift(ACT_ADD, 20240101, 126000, 0);
		send_shift(ACT_SUB, 20240101, 120060, 0);
		send_shift(ACT_ADD, 20240101, 120000, 240001);
		send_shift(ACT_ADD, 20240101, 120000, 6000);
		send_shift(ACT_SUB, 20240101, 120000, 60);
		send_shift(ACT_ADD, 0, 0, 0);
		send_shift(ACT_SUB, '1, '1, '1);
		send_shift(ACT_SUB, 20240615, 0, 0);
		send_shift(ACT_ADD, 99991231, 0, 235959);
		wait_results_drained();
	endtask

	// result side held off while requests keep coming, then a full drain
	task automatic test_full_stall();
		sink_hold = 48;
		source_steady = 1'b1;
		repeat (24) send_random_shift(KIND_CLEAN);
		source_steady = 1'b0;
		wait_results_drained();
	endtask

	// both sides without idle cycles
	task automatic test_back_to_back();
		source_steady = 1'b1;
		sink_steady = 1'b1;
		repeat (60) send_random_shift(KIND_CLEAN);
		source_steady = 1'b0;
		sink_steady = 1'b0;
		wait_results_drained();
	endtask

	// mostly well-formed stamps, some broken fields and raw noise
	task automatic test_random_stream();
		int unsigned r;
		for (int n = 0; n < 600; n++) begin
			if (n % 50 == 0) begin
				source_steady = ($urandom_range(0, 3) == 0);
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 80) send_random_shift(KIND_CLEAN);
			else if (r < 92) send_random_shift(KIND_BROKEN);
			else send_random_shift(KIND_RAW);
		end
		source_steady = 1'b0;
		sink_steady = 1'b0;
		wait_results_drained();
	endtask

	// result side ready with random stalls and requested hold-offs
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				res_ch.ready = 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				res_ch.ready = 1'b0;
				sink_stall--;
			end else begin
				res_ch.ready = 1'b1;
				if (!sink_steady && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_stamps.size() == 0) begin
				report_error($sformatf("unrequested result date %0d time %0d",
					res_ch.new_date, res_ch.new_time));
			end else begin
				want_stamp = awaited_stamps.pop_front();
				if (res_ch.new_date !== want_stamp.date_out)
					report_error($sformatf("new_date got %0d want %0d",
						res_ch.new_date, want_stamp.date_out));
				if (res_ch.new_time !== want_stamp.tod_out)
					report_error($sformatf("new_time got %0d want %0d",
						res_ch.new_time, want_stamp.tod_out));
				if (res_ch.bad_input !== want_stamp.bad)
					report_error($sformatf("bad_input got %b want %b for date %0d",
						res_ch.bad_input, want_stamp.bad, want_stamp.date_out));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("date_time_add_subtract_tb: errors");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ADD;
		req_ch.date_value = '0;
		req_ch.time_value = '0;
		req_ch.interval = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_full_stall();
		test_back_to_back();
		test_random_stream();

		wait_results_drained();
		repeat (NUM_STAGES + 8) @(posedge clk);
		if (error_count == 0)
			$display("date_time_add_subtract_tb: clean");
		else
			$display("date_time_add_subtract_tb: errors");
		$finish;
	end

endmodule
